// ----- rtl/sepd_pkg.sv -----
`default_nettype none
package sepd_pkg;

  localparam int SEGMENT_POINTS_DEF = 20;

  localparam int COORD_W = 32;
  // sums are sized for the largest group size of 64 points
  localparam int SUM_W   = 38;
  // box bounds: (centre +/- half) times group size
  localparam int BND_W   = 39;
  localparam int GRP_W   = 16;
  localparam int DIST_W  = 63;
  localparam int PROD_W  = 64;

  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [BND_W-1:0]  BOX_HALF   = 39'sd2816000;
  localparam logic        [31:0]       ROOT_LIMIT = 32'd3037000499;
  localparam logic        [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

  localparam logic signed [COORD_W-1:0] COEF_ONE  = 32'sd65536;
  localparam logic signed [COORD_W-1:0] COEF_ZERO = 32'sd0;

  typedef enum logic [2:0] {
    CFG_COEF_XX  = 3'd0,
    CFG_COEF_XY  = 3'd1,
    CFG_SHIFT_X  = 3'd2,
    CFG_COEF_YX  = 3'd3,
    CFG_COEF_YY  = 3'd4,
    CFG_SHIFT_Y  = 3'd5,
    CFG_CENTER_X = 3'd6,
    CFG_CENTER_Y = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coef_xx;
    logic signed [COORD_W-1:0] coef_xy;
    logic signed [COORD_W-1:0] shift_x;
    logic signed [COORD_W-1:0] coef_yx;
    logic signed [COORD_W-1:0] coef_yy;
    logic signed [COORD_W-1:0] shift_y;
    logic signed [COORD_W-1:0] center_x_pos;
    logic signed [COORD_W-1:0] center_y_pos;
  } cfg_regs_t;

  // one endpoint of a group, handed from the front to the back
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic        [GRP_W-1:0]   grp;
    logic                      is_first;
    logic                      is_last;
  } job_t;

endpackage
`default_nettype wire

// ----- rtl/sepd_front.sv -----
`default_nettype none
module sepd_front #(
  parameter int SEGMENT_POINTS = sepd_pkg::SEGMENT_POINTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [sepd_pkg::COORD_W-1:0] in_point_x,
  input  wire logic signed [sepd_pkg::COORD_W-1:0] in_point_y,
  input  wire logic                                full,
  output logic                                     push,
  output sepd_pkg::job_t                           job
);
  import sepd_pkg::*;

  localparam int CNT_W = $clog2(SEGMENT_POINTS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SEGMENT_POINTS - 1);

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] sum_x_r, sum_x_nxt;
  logic signed [SUM_W-1:0] sum_y_r, sum_y_nxt;
  logic [GRP_W-1:0]        grp_r, grp_nxt;
  logic signed [SUM_W-1:0] xe, ye;
  logic                    accept, at_first, at_last;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign at_first = (cnt_r == '0);
  assign at_last  = (cnt_r == CNT_LAST);

  assign xe = {{(SUM_W-COORD_W){in_point_x[COORD_W-1]}}, in_point_x};
  assign ye = {{(SUM_W-COORD_W){in_point_y[COORD_W-1]}}, in_point_y};

  always_comb begin
    cnt_nxt   = cnt_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    grp_nxt   = grp_r;
    if (accept) begin
      if (at_last) begin
        cnt_nxt   = '0;
        sum_x_nxt = '0;
        sum_y_nxt = '0;
        grp_nxt   = grp_r + 1'b1;
      end else begin
        cnt_nxt   = cnt_r + 1'b1;
        sum_x_nxt = sum_x_r + xe;
        sum_y_nxt = sum_y_r + ye;
      end
    end
  end

  // only the two endpoints of a group need the transform
  assign push         = accept && (at_first || at_last);
  assign job.x        = in_point_x;
  assign job.y        = in_point_y;
  assign job.sum_x    = sum_x_r + xe;
  assign job.sum_y    = sum_y_r + ye;
  assign job.grp      = grp_r;
  assign job.is_first = at_first;
  assign job.is_last  = at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      grp_r   <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      grp_r   <= grp_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sepd_fifo.sv -----
`default_nettype none
module sepd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire sepd_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output sepd_pkg::job_t      pop_job,
  output logic                empty
);
  import sepd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sepd_back.sv -----
`default_nettype none
module sepd_back #(
  parameter int SEGMENT_POINTS = sepd_pkg::SEGMENT_POINTS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire sepd_pkg::cfg_regs_t                cfg,
  input  wire logic                               empty,
  input  wire sepd_pkg::job_t                     job_in,
  output logic                                    pop,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [sepd_pkg::GRP_W-1:0]              out_segment_number,
  output logic [sepd_pkg::DIST_W-1:0]             out_min_dist_sq,
  output logic                                    out_inside_res
);
  import sepd_pkg::*;

  typedef enum logic [2:0] {
    ST_MXX,   // xx*x
    ST_MXY,   // xy*y
    ST_MYX,   // yx*x, row 0 reduced
    ST_MYY,   // yy*y
    ST_SQ0,   // row 0 squared, row 1 reduced
    ST_SQ1,   // row 1 squared
    ST_SUM,   // sum of squares with saturation
    ST_DONE   // keep first distance or deliver the word
  } step_t;

  localparam logic signed [BND_W-1:0] N_MUL = BND_W'(SEGMENT_POINTS);

  step_t                     step_r;
  logic                      busy_r;
  job_t                      job_r;
  logic signed [PROD_W-1:0]  pa_r, prod_r;
  logic [31:0]               m0_r, m1_r;
  logic                      s0_r, s1_r;
  logic [DIST_W-1:0]         sq0_r, d_r, first_r;
  logic signed [BND_W-1:0]   lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic                      inside_r;
  logic                      out_valid_r;
  logic [GRP_W-1:0]          out_grp_r;
  logic [DIST_W-1:0]         out_dist_r;
  logic                      out_inside_r;

  logic signed [32:0]        op_a, op_b;
  logic signed [65:0]        mul;
  logic signed [COORD_W-1:0] tr;
  logic signed [65:0]        row_sum;
  logic [49:0]               row_q, row_mag;
  logic                      row_sat;
  logic [PROD_W-1:0]         sq_sum;
  logic [DIST_W-1:0]         d_nxt, best;
  logic signed [BND_W-1:0]   cxe, cye, sxe, sye;
  logic                      out_free;
  logic                      deliver;

  assign pop = !busy_r && !empty;

  // one shared 33x33 signed multiplier
  always_comb begin
    unique case (step_r)
      ST_MXX:  begin op_a = {cfg.coef_xx[31], cfg.coef_xx}; op_b = {job_r.x[31], job_r.x}; end
      ST_MXY:  begin op_a = {cfg.coef_xy[31], cfg.coef_xy}; op_b = {job_r.y[31], job_r.y}; end
      ST_MYX:  begin op_a = {cfg.coef_yx[31], cfg.coef_yx}; op_b = {job_r.x[31], job_r.x}; end
      ST_MYY:  begin op_a = {cfg.coef_yy[31], cfg.coef_yy}; op_b = {job_r.y[31], job_r.y}; end
      ST_SQ0:  begin op_a = {1'b0, m0_r}; op_b = {1'b0, m0_r}; end
      ST_SQ1:  begin op_a = {1'b0, m1_r}; op_b = {1'b0, m1_r}; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign mul = op_a * op_b;

  // row reduction: round half up from q.24 down to q.8
  assign tr      = (step_r == ST_MYX) ? cfg.shift_x : cfg.shift_y;
  assign row_sum = {{2{pa_r[PROD_W-1]}}, pa_r} + {{2{prod_r[PROD_W-1]}}, prod_r}
                 + {{18{tr[COORD_W-1]}}, tr, 16'h0000} + 66'sd32768;
  assign row_q   = row_sum[65:16];
  assign row_mag = row_q[49] ? (~row_q + 50'd1) : row_q;
  assign row_sat = (row_mag > {18'd0, ROOT_LIMIT});

  assign sq_sum = {1'b0, sq0_r} + {1'b0, prod_r[DIST_W-1:0]};
  assign d_nxt  = (s0_r || s1_r || sq_sum[PROD_W-1]) ? DIST_MAX : sq_sum[DIST_W-1:0];
  assign best   = (d_r < first_r) ? d_r : first_r;

  assign cxe = {{(BND_W-COORD_W){cfg.center_x_pos[COORD_W-1]}}, cfg.center_x_pos};
  assign cye = {{(BND_W-COORD_W){cfg.center_y_pos[COORD_W-1]}}, cfg.center_y_pos};
  assign sxe = {{(BND_W-SUM_W){job_r.sum_x[SUM_W-1]}}, job_r.sum_x};
  assign sye = {{(BND_W-SUM_W){job_r.sum_y[SUM_W-1]}}, job_r.sum_y};

  assign out_free = !out_valid_r || out_ready;
  assign deliver  = busy_r && (step_r == ST_DONE) && job_r.is_last && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= ST_MXX;
      out_valid_r <= 1'b0;
      first_r     <= '0;
    end else begin
      if (out_valid_r && out_ready && !deliver) begin
        out_valid_r <= 1'b0;
      end
      if (!busy_r) begin
        step_r <= ST_MXX;
        if (pop) begin
          job_r  <= job_in;
          busy_r <= 1'b1;
        end
      end else begin
        unique case (step_r)
          ST_MXX: begin
            lo_x_r <= (cxe - BOX_HALF) * N_MUL;
            hi_x_r <= (cxe + BOX_HALF) * N_MUL;
            lo_y_r <= (cye - BOX_HALF) * N_MUL;
            hi_y_r <= (cye + BOX_HALF) * N_MUL;
            step_r <= ST_MXY;
          end
          ST_MXY: begin
            pa_r     <= prod_r;
            inside_r <= (sxe > lo_x_r) && (sxe < hi_x_r) && (sye > lo_y_r) && (sye < hi_y_r);
            step_r   <= ST_MYX;
          end
          ST_MYX: begin
            m0_r   <= row_mag[31:0];
            s0_r   <= row_sat;
            step_r <= ST_MYY;
          end
          ST_MYY: begin
            pa_r   <= prod_r;
            step_r <= ST_SQ0;
          end
          ST_SQ0: begin
            m1_r   <= row_mag[31:0];
            s1_r   <= row_sat;
            step_r <= ST_SQ1;
          end
          ST_SQ1: begin
            sq0_r  <= prod_r[DIST_W-1:0];
            step_r <= ST_SUM;
          end
          ST_SUM: begin
            d_r    <= d_nxt;
            step_r <= ST_DONE;
          end
          ST_DONE: begin
            if (job_r.is_last) begin
              if (out_free) begin
                out_valid_r  <= 1'b1;
                out_grp_r    <= job_r.grp;
                out_dist_r   <= best;
                out_inside_r <= inside_r;
                busy_r       <= 1'b0;
                step_r       <= ST_MXX;
              end
            end else begin
              first_r <= d_r;
              busy_r  <= 1'b0;
              step_r  <= ST_MXX;
            end
          end
          default: step_r <= ST_MXX;
        endcase
      end
      prod_r <= mul[PROD_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_segment_number = out_grp_r;
  assign out_min_dist_sq    = out_dist_r;
  assign out_inside_res     = out_inside_r;

  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |=> (step_r == ST_MXX) || busy_r)
    else $error("sequencer left mid-step while idle");

  a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (step_r == ST_DONE) && job_r.is_last && out_valid_r && !out_ready
    |=> busy_r && (step_r == ST_DONE))
    else $error("last endpoint dropped while output stalled");

  a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (step_r == ST_DONE) && job_r.is_last && out_free
    |=> out_valid_r && !busy_r)
    else $error("finished group not delivered");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !pop)
    else $error("queue popped while sequencer busy");

  a_one_end: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (job_r.is_first != job_r.is_last))
    else $error("job is not a single endpoint of its group");

endmodule
`default_nettype wire

// ----- rtl/segment_endpoint_distance_and_box.sv -----
`default_nettype none
// channel   direction  handshake             payload
// in_       input      in_valid / in_ready   in_point_x, in_point_y
// out_      output     out_valid / out_ready out_segment_number, out_min_dist_sq,
//                                            out_inside_res
// cfg_      input      cfg_we                cfg_index, cfg_data
//
// points are taken one per cycle while the endpoint queue has room
// each endpoint of a group holds the back end for its pop and eight steps, MXX to DONE
// groups of 18 or more points stream at one point per cycle unless out_ready stalls
// a finished word is registered at DONE of its last endpoint once the output is free
// synchronous active-low reset, registers return to identity transform, no clear pass
// out_ready low holds the back end, the queue then fills and in_ready drops
module segment_endpoint_distance_and_box #(
  parameter int SEGMENT_POINTS = sepd_pkg::SEGMENT_POINTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [sepd_pkg::COORD_W-1:0] in_point_x,
  input  wire logic signed [sepd_pkg::COORD_W-1:0] in_point_y,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [sepd_pkg::GRP_W-1:0]               out_segment_number,
  output logic [sepd_pkg::DIST_W-1:0]              out_min_dist_sq,
  output logic                                     out_inside_res,
  input  wire logic                                cfg_we,
  input  wire logic [2:0]                          cfg_index,
  input  wire logic [sepd_pkg::COORD_W-1:0]        cfg_data
);
  import sepd_pkg::*;

  cfg_regs_t cfg_r;
  job_t      push_job, pop_job;
  logic      push, pop, full, empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_xx      <= COEF_ONE;
      cfg_r.coef_xy      <= COEF_ZERO;
      cfg_r.shift_x      <= COEF_ZERO;
      cfg_r.coef_yx      <= COEF_ZERO;
      cfg_r.coef_yy      <= COEF_ONE;
      cfg_r.shift_y      <= COEF_ZERO;
      cfg_r.center_x_pos <= COEF_ZERO;
      cfg_r.center_y_pos <= COEF_ZERO;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COEF_XX:  cfg_r.coef_xx      <= cfg_data;
        CFG_COEF_XY:  cfg_r.coef_xy      <= cfg_data;
        CFG_SHIFT_X:  cfg_r.shift_x      <= cfg_data;
        CFG_COEF_YX:  cfg_r.coef_yx      <= cfg_data;
        CFG_COEF_YY:  cfg_r.coef_yy      <= cfg_data;
        CFG_SHIFT_Y:  cfg_r.shift_y      <= cfg_data;
        CFG_CENTER_X: cfg_r.center_x_pos <= cfg_data;
        CFG_CENTER_Y: cfg_r.center_y_pos <= cfg_data;
        default:      cfg_r              <= cfg_r;
      endcase
    end
  end

  sepd_front #(
    .SEGMENT_POINTS(SEGMENT_POINTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .full       (full),
    .push       (push),
    .job        (push_job)
  );

  sepd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  sepd_back #(
    .SEGMENT_POINTS(SEGMENT_POINTS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .empty              (empty),
    .job_in             (pop_job),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_segment_number (out_segment_number),
    .out_min_dist_sq    (out_min_dist_sq),
    .out_inside_res     (out_inside_res)
  );

endmodule
`default_nettype wire
